/* rtl/token_bucket_packet_shaper_defines.svh */
// assertion macros for the token bucket packet shaper
// used by the rtl files that carry assertions; expects clk_i and rst_ni in scope
`ifndef TOKEN_BUCKET_PACKET_SHAPER_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_DEFINES_SVH
`ifndef SYNTH
`define TBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TBPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TBPS_ASSERT(lbl, prop, msg)
`define TBPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/tbps_pkg.sv */
// package for the token bucket packet shaper: sizes, register map and payload types
// no dependencies
package tbps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W     = 3;
  localparam int REG_IDX_W   = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BUCKET_CAPACITY = REG_IDX_W'(0);
  localparam logic [15:0] CAPACITY_RESET = 16'd10;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ARRIVAL = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] packet_id;
    logic [15:0] tokens_needed;
  } tbps_in_t;

  typedef struct packed {
    logic        released;
    logic [15:0] released_id;
    logic        packet_dropped;
    logic        queue_overflow;
    logic        token_dropped;
    logic [15:0] tokens_now;
    logic [4:0]  queue_count;
    logic [31:0] dropped_token_total;
    logic [31:0] dropped_packet_total;
  } tbps_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] need;
  } tbps_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } tbps_q_ctrl_t;

endpackage

/* rtl/tbps_wait_queue.sv */
// circular queue of waiting packets: register file with head and tail pointers
// depends on tbps_pkg and token_bucket_packet_shaper_defines.svh
`include "token_bucket_packet_shaper_defines.svh"

module tbps_wait_queue
  import tbps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbps_q_ctrl_t        ctrl_i,
  input  tbps_entry_t         push_entry_i,
  output tbps_entry_t         head_entry_o,
  output logic [CNT_W-1:0]    count_o
);

  tbps_entry_t          entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     head_q, head_d;
  logic [PTR_W-1:0]     tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + CNT_W'(1);
    end
    if (ctrl_i.pop) begin
      head_d  = next_ptr(head_q);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      entries_q[tail_q] <= push_entry_i;
    end
  end

  assign head_entry_o = entries_q[head_q];
  assign count_o      = count_q;

  `TBPS_ASSERT(a_no_push_and_pop, !(ctrl_i.push && ctrl_i.pop), "push and pop together")
  `TBPS_ASSERT(a_no_push_full, ctrl_i.push |-> (count_q < CNT_W'(QUEUE_DEPTH)),
               "push into full queue")
  `TBPS_ASSERT(a_no_pop_empty, ctrl_i.pop |-> (count_q != '0), "pop from empty queue")
  `TBPS_ASSERT(a_empty_ptrs, (count_q == '0) |-> (head_q == tail_q),
               "empty queue with pointers apart")
  `TBPS_ASSERT_ALWAYS(a_count_range, !rst_ni || (count_q <= CNT_W'(QUEUE_DEPTH)),
                      "queue count out of range")

endmodule

/* rtl/token_bucket_packet_shaper.sv */
// token bucket packet shaper: one result per tick or arrival
// from transfer in to result valid: input register, then result register
// throughput one item per cycle unless stalled; bucket, queue, counters update in a single pass
// reset: capacity 10, bucket empty, queue empty, drop counters zero; queue entries not cleared
// depends on tbps_pkg, tbps_wait_queue and token_bucket_packet_shaper_defines.svh
`include "token_bucket_packet_shaper_defines.svh"

module token_bucket_packet_shaper
  import tbps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbps_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbps_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               stage_valid_q, stage_valid_d;
  tbps_in_t           stage_q;
  logic               out_valid_q, out_valid_d;
  tbps_out_t          out_q, out_d;
  logic [15:0]        capacity_q;
  logic [15:0]        level_q, level_d;
  logic [31:0]        tok_drops_q, tok_drops_d;
  logic [31:0]        pkt_drops_q, pkt_drops_d;
  logic               advance;
  logic               in_take;
  logic               cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  tbps_q_ctrl_t       q_ctrl;
  tbps_entry_t        push_entry;
  tbps_entry_t        head_entry;
  logic [CNT_W-1:0]   q_count;
  logic [CNT_W-1:0]   q_count_after;
  logic [15:0]        tick_level;

  assign advance    = stage_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stage_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_BUCKET_CAPACITY);

  always_comb begin
    case (reg_idx)
      REG_BUCKET_CAPACITY: prdata = {16'd0, capacity_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity_q <= pwdata[15:0];
    end
  end

  tbps_wait_queue u_wait_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (q_ctrl),
    .push_entry_i (push_entry),
    .head_entry_o (head_entry),
    .count_o      (q_count)
  );

  assign push_entry.id   = stage_q.packet_id;
  assign push_entry.need = stage_q.tokens_needed;

  always_comb begin
    level_d       = level_q;
    tok_drops_d   = tok_drops_q;
    pkt_drops_d   = pkt_drops_q;
    q_ctrl        = '0;
    q_count_after = q_count;
    out_d         = '0;
    tick_level    = level_q;

    if (stage_q.op == OP_TICK) begin
      if (level_q >= capacity_q) begin
        out_d.token_dropped = 1'b1;
        tok_drops_d = (tok_drops_q == '1) ? tok_drops_q : tok_drops_q + 32'd1;
      end else begin
        tick_level = level_q + 16'd1;
      end
      level_d = tick_level;
      if ((q_count != '0) && (tick_level >= head_entry.need)) begin
        level_d           = tick_level - head_entry.need;
        out_d.released    = 1'b1;
        out_d.released_id = head_entry.id;
        q_ctrl.pop        = 1'b1;
        q_count_after     = q_count - CNT_W'(1);
      end
    end else begin
      if (stage_q.tokens_needed > capacity_q) begin
        out_d.packet_dropped = 1'b1;
        pkt_drops_d = (pkt_drops_q == '1) ? pkt_drops_q : pkt_drops_q + 32'd1;
      end else if (q_count >= CNT_W'(QUEUE_DEPTH)) begin
        out_d.packet_dropped = 1'b1;
        out_d.queue_overflow = 1'b1;
        pkt_drops_d = (pkt_drops_q == '1) ? pkt_drops_q : pkt_drops_q + 32'd1;
      end else if ((q_count == '0) && (level_q >= stage_q.tokens_needed)) begin
        level_d           = level_q - stage_q.tokens_needed;
        out_d.released    = 1'b1;
        out_d.released_id = stage_q.packet_id;
      end else begin
        q_ctrl.push   = 1'b1;
        q_count_after = q_count + CNT_W'(1);
      end
    end

    out_d.tokens_now           = level_d;
    out_d.queue_count          = 5'(q_count_after);
    out_d.dropped_token_total  = tok_drops_d;
    out_d.dropped_packet_total = pkt_drops_d;

    if (!advance) begin
      q_ctrl = '0;
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_take) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      level_q       <= '0;
      tok_drops_q   <= '0;
      pkt_drops_q   <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
      if (advance) begin
        level_q     <= level_d;
        tok_drops_q <= tok_drops_d;
        pkt_drops_q <= pkt_drops_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stage_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TBPS_ASSERT(a_ovf_is_drop, (out_valid_q && out_q.queue_overflow) |-> out_q.packet_dropped, "overflow without drop")
  `TBPS_ASSERT(a_rel_drop_excl, out_valid_q |-> !(out_q.released && out_q.packet_dropped), "packet released and dropped")
  `TBPS_ASSERT(a_tok_pkt_excl, out_valid_q |-> !(out_q.token_dropped && out_q.packet_dropped), "token and packet drop together")
  `TBPS_ASSERT(a_idle_id_zero, (out_valid_q && !out_q.released) |-> (out_q.released_id == '0), "id without release")

endmodule

/* tb/token_bucket_packet_shaper_tb.sv */
// self-checking testbench for token_bucket_packet_shaper: directed and random ticks and arrivals
// with random gaps and output stalls, results checked against an in-bench shaper model
// depends on tbps_pkg and the token_bucket_packet_shaper rtl
module token_bucket_packet_shaper_tb
  import tbps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'({REG_BUCKET_CAPACITY, 2'b00});
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(4 * (REG_BUCKET_CAPACITY + 1));

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  tbps_in_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tbps_out_t          out_data_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  token_bucket_packet_shaper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // shaper model state
  logic [15:0] cap_model = CAPACITY_RESET;
  logic [15:0] bucket_level = '0;
  logic [15:0] waiting_id [QUEUE_DEPTH];
  logic [15:0] waiting_need [QUEUE_DEPTH];
  logic [3:0]  wait_head = '0;
  logic [3:0]  wait_tail = '0;
  logic [4:0]  wait_count = '0;
  logic [31:0] token_drops = '0;
  logic [31:0] packet_drops = '0;

  tbps_in_t  input_backlog[$];
  tbps_out_t expected_results[$];
  int        mismatch_count = 0;
  int        result_index = 0;
  int        quiet_cycles = 0;
  int        in_gap = 0;
  int        in_calm = 0;
  int        stall_left = 0;
  int        flow_left = 0;
  int        out_calm = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic tbps_out_t shape_item(tbps_in_t it);
    tbps_out_t r;
    r = '0;
    if (it.op == OP_TICK) begin
      if (bucket_level >= cap_model) begin
        r.token_dropped = 1'b1;
        token_drops = sat_bump(token_drops);
      end else begin
        bucket_level = bucket_level + 16'd1;
      end
      if (wait_count != 0 && bucket_level >= waiting_need[wait_head]) begin
        bucket_level  = bucket_level - waiting_need[wait_head];
        r.released    = 1'b1;
        r.released_id = waiting_id[wait_head];
        wait_head     = wait_head + 4'd1;
        wait_count    = wait_count - 5'd1;
      end
    end else if (it.tokens_needed > cap_model) begin
      r.packet_dropped = 1'b1;
      packet_drops = sat_bump(packet_drops);
    end else if (wait_count >= QUEUE_DEPTH) begin
      r.packet_dropped = 1'b1;
      r.queue_overflow = 1'b1;
      packet_drops = sat_bump(packet_drops);
    end else if (wait_count == 0 && bucket_level >= it.tokens_needed) begin
      bucket_level  = bucket_level - it.tokens_needed;
      r.released    = 1'b1;
      r.released_id = it.packet_id;
    end else begin
      waiting_id[wait_tail]   = it.packet_id;
      waiting_need[wait_tail] = it.tokens_needed;
      wait_tail  = wait_tail + 4'd1;
      wait_count = wait_count + 5'd1;
    end
    r.tokens_now           = bucket_level;
    r.queue_count          = wait_count;
    r.dropped_token_total  = token_drops;
    r.dropped_packet_total = packet_drops;
    return r;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tbps_in_t item_of(logic op, logic [15:0] id, logic [15:0] need);
    tbps_in_t it;
    it.op            = op;
    it.packet_id     = id;
    it.tokens_needed = need;
    return it;
  endfunction

  function automatic tbps_in_t random_item(logic [15:0] cap, int tick_pct);
    tbps_in_t it;
    int r;
    it.packet_id     = 16'($urandom);
    it.tokens_needed = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      it.op = OP_TICK;
    end else begin
      it.op = OP_ARRIVAL;
      r = $urandom_range(0, 99);
      if (r < 80) it.tokens_needed = 16'($urandom_range(0, (cap < 8) ? cap : 8));
      else if (r < 92) it.tokens_needed = 16'($urandom_range(0, cap));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", result_index, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic wait_idle();
    while (input_backlog.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == CAP_ADDR) begin
      cap_model = val[15:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      check_field("capacity readback", {16'd0, prdata[15:0]}, {16'd0, val[15:0]});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (input_backlog.size() != 0) begin
        in_data_i  <= input_backlog.pop_front();
        in_valid_i <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = pick_gap(out_calm);
      flow_left  = $urandom_range(0, 5);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    tbps_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(shape_item(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_data_o.tokens_now), '0);
        end else begin
          want = expected_results.pop_front();
          check_field("released", 32'(out_data_o.released), 32'(want.released));
          check_field("released_id", 32'(out_data_o.released_id), 32'(want.released_id));
          check_field("packet_dropped", 32'(out_data_o.packet_dropped),
                      32'(want.packet_dropped));
          check_field("queue_overflow", 32'(out_data_o.queue_overflow),
                      32'(want.queue_overflow));
          check_field("token_dropped", 32'(out_data_o.token_dropped), 32'(want.token_dropped));
          check_field("tokens_now", 32'(out_data_o.tokens_now), 32'(want.tokens_now));
          check_field("queue_count", 32'(out_data_o.queue_count), 32'(want.queue_count));
          check_field("dropped_token_total", out_data_o.dropped_token_total,
                      want.dropped_token_total);
          check_field("dropped_packet_total", out_data_o.dropped_packet_total,
                      want.dropped_packet_total);
        end
        result_index++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("token_bucket_packet_shaper test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cap_plan [12];
    int          tick_pct;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity: immediate release, zero need, over-capacity drops, queued release
    input_backlog.push_back(item_of(OP_TICK, 16'h0000, 16'h0000));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'hFFFF, 16'h0000));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'h0000, 16'hFFFF));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'h1234, 16'd11));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'hA5A5, 16'd3));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'h5A5A, 16'd0));
    input_backlog.push_back(item_of(OP_TICK, 16'hFFFF, 16'hFFFF));
    input_backlog.push_back(item_of(OP_TICK, 16'h0000, 16'h0000));
    input_backlog.push_back(item_of(OP_TICK, 16'h0000, 16'h0000));
    wait_idle();

    // tiny bucket: full bucket drops the token, then fill the queue to overflow
    write_reg(UNUSED_ADDR, 32'hFFFF_FFFF);
    write_reg(CAP_ADDR, 32'd1);
    input_backlog.push_back(item_of(OP_TICK, 16'h0000, 16'h0000));
    input_backlog.push_back(item_of(OP_TICK, 16'h0000, 16'h0000));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'h0001, 16'd1));
    for (int i = 0; i < QUEUE_DEPTH; i++)
      input_backlog.push_back(item_of(OP_ARRIVAL, 16'(16'h0100 + i), 16'd1));
    input_backlog.push_back(item_of(OP_ARRIVAL, 16'hBEEF, 16'd1));
    wait_idle();

    cap_plan = '{16'd0, 16'd3, 16'd65535, 16'd1, 16'd7, 16'd20,
                 16'd65535, 16'd2, 16'd0, 16'd12, 16'd0, 16'd5};
    cap_plan[8] = 16'($urandom);
    for (int p = 0; p < 12; p++) begin
      write_reg(CAP_ADDR, {16'($urandom), cap_plan[p]});
      tick_pct = (p % 2 == 0) ? 58 : 80;
      for (int i = 0; i < 150; i++) input_backlog.push_back(random_item(cap_plan[p], tick_pct));
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("token_bucket_packet_shaper test passed");
    end else begin
      $display("token_bucket_packet_shaper test failed");
    end
    $finish;
  end

endmodule
